[src/pfe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_pkg
// Types, codes and small helper functions shared by the Playfair encryptor.
// ----------------------------------------------------------------------------
package pfe_pkg;

   localparam int SIDE     = 5;
   localparam int CELLS    = SIDE * SIDE;
   localparam int NLETTERS = 26;

   localparam logic [4:0] LTR_A = 5'd0;
   localparam logic [4:0] LTR_I = 5'd8;
   localparam logic [4:0] LTR_J = 5'd9;
   localparam logic [4:0] LTR_X = 5'd23;

   localparam logic [1:0] KIND_KEY  = 2'd0;
   localparam logic [1:0] KIND_FILL = 2'd1;
   localparam logic [1:0] KIND_PAIR = 2'd2;

   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_NOT_READY = 1'b1;

   typedef struct packed {
      logic [1:0] kind;
      logic [4:0] letter_a;
      logic [4:0] letter_b;
      logic       b_present;
   } req_type;

   typedef struct packed {
      logic [4:0] cipher_a;
      logic [4:0] cipher_b;
      logic       status;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_LOOK_PLACE,
      ST_LOOK_CELL
   } state_type;

   typedef struct packed {
      logic key_place;
      logic fill_start;
      logic fill_step;
      logic pair_capture;
      logic cell_read;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic square_ready;
      logic fill_last;
      logic rsp_free;
   } sts_type;

   function automatic logic [4:0] fold_letter(input logic [4:0] v);
      return (v == LTR_J) ? LTR_I : v;
   endfunction

   // row of a cell index below 25
   function automatic logic [2:0] row_of(input logic [4:0] p);
      logic [2:0] r;
      if (p >= 5'd20) begin
         r = 3'd4;
      end else if (p >= 5'd15) begin
         r = 3'd3;
      end else if (p >= 5'd10) begin
         r = 3'd2;
      end else if (p >= 5'd5) begin
         r = 3'd1;
      end else begin
         r = 3'd0;
      end
      return r;
   endfunction

   function automatic logic [4:0] row_base(input logic [2:0] r);
      return ({2'b00, r} << 2) + {2'b00, r};
   endfunction

   function automatic logic [2:0] col_of(input logic [4:0] p);
      logic [4:0] c;
      c = p - row_base(row_of(p));
      return c[2:0];
   endfunction

   function automatic logic [2:0] wrap_inc(input logic [2:0] x);
      return (x == 3'(SIDE - 1)) ? 3'd0 : x + 3'd1;
   endfunction

   function automatic logic [4:0] cell_index(input logic [2:0] r, input logic [2:0] c);
      return row_base(r) + {2'b00, c};
   endfunction

endpackage

[src/pfe_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_ctrl
// Sequencer for key placement, square fill and pair lookup.
// ----------------------------------------------------------------------------
module pfe_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [1:0]       req_kind,
   input  pfe_pkg::sts_type sts,
   output logic             req_stall,
   output pfe_pkg::cmd_type cmd
);

   pfe_pkg::state_type state_ff, state_in;
   logic accept;

   assign accept = req_valid && (state_ff == pfe_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pfe_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pfe_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_kind == pfe_pkg::KIND_PAIR) begin
                  state_in = pfe_pkg::ST_LOOK_PLACE;
               end else if (req_kind == pfe_pkg::KIND_FILL && !sts.square_ready) begin
                  state_in = pfe_pkg::ST_FILL;
               end
            end
         end
         pfe_pkg::ST_FILL: begin
            if (sts.fill_last) begin
               state_in = pfe_pkg::ST_IDLE;
            end
         end
         pfe_pkg::ST_LOOK_PLACE: begin
            state_in = pfe_pkg::ST_LOOK_CELL;
         end
         pfe_pkg::ST_LOOK_CELL: begin
            if (sts.rsp_free) begin
               state_in = pfe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pfe_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall        = (state_ff != pfe_pkg::ST_IDLE);
      cmd              = '0;
      cmd.key_place    = accept && (req_kind == pfe_pkg::KIND_KEY);
      cmd.fill_start   = accept && (req_kind == pfe_pkg::KIND_FILL) && !sts.square_ready;
      cmd.pair_capture = accept && (req_kind == pfe_pkg::KIND_PAIR);
      cmd.fill_step    = (state_ff == pfe_pkg::ST_FILL);
      cmd.cell_read    = (state_ff == pfe_pkg::ST_LOOK_PLACE);
      cmd.rsp_load     = (state_ff == pfe_pkg::ST_LOOK_CELL) && sts.rsp_free;
   end

endmodule

[src/pfe_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_datapath
// Key square and place table memories, letter bookkeeping and result register.
// ----------------------------------------------------------------------------
module pfe_datapath (
   input  logic             clock,
   input  logic             reset,
   input  pfe_pkg::req_type req_data,
   input  pfe_pkg::cmd_type cmd,
   output pfe_pkg::sts_type sts,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output pfe_pkg::rsp_type rsp_data
);

   logic [4:0] square_mem [0:pfe_pkg::CELLS-1];
   logic [4:0] place_mem  [0:pfe_pkg::NLETTERS-1];

   logic [pfe_pkg::NLETTERS-1:0] used_ff, used_in, used_eff;
   logic [4:0]       fill_ff, fill_in, fill_eff;
   logic             ready_ff, ready_in;
   logic [4:0]       fill_v_ff;
   logic             notready_ff;
   logic [4:0]       place_a_ff, place_b_ff;
   logic [4:0]       cell_a_ff, cell_b_ff;
   logic             rsp_valid_ff;
   pfe_pkg::rsp_type rsp_ff;

   logic       restart;
   logic [4:0] wr_letter;
   logic       wr_ok, wr_en;
   logic [4:0] pair_a, pair_b;
   logic [2:0] r1, c1, r2, c2;
   logic [4:0] addr_a, addr_b;

   // a key letter after completion starts a new square
   assign restart   = cmd.key_place && ready_ff;
   assign used_eff  = restart ? '0 : used_ff;
   assign fill_eff  = restart ? 5'd0 : fill_ff;
   assign wr_letter = cmd.fill_step ? fill_v_ff : pfe_pkg::fold_letter(req_data.letter_a);
   assign wr_ok     = cmd.fill_step ||
                      (cmd.key_place && (req_data.letter_a < 5'(pfe_pkg::NLETTERS)));
   assign wr_en     = wr_ok && (wr_letter != pfe_pkg::LTR_J) && !used_eff[wr_letter] &&
                      (fill_eff < 5'(pfe_pkg::CELLS));

   always_comb begin
      used_in  = used_eff;
      fill_in  = fill_eff;
      ready_in = restart ? 1'b0 : ready_ff;
      if (wr_en) begin
         used_in = used_eff | (pfe_pkg::NLETTERS'(1) << wr_letter);
         fill_in = fill_eff + 5'd1;
      end
      if (cmd.fill_step && sts.fill_last) begin
         ready_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         fill_ff  <= 5'd0;
         ready_ff <= 1'b0;
      end else begin
         used_ff  <= used_in;
         fill_ff  <= fill_in;
         ready_ff <= ready_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fill_start) begin
         fill_v_ff <= pfe_pkg::LTR_A;
      end else if (cmd.fill_step) begin
         fill_v_ff <= fill_v_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         square_mem[fill_eff] <= wr_letter;
         place_mem[wr_letter] <= fill_eff;
      end
   end

   // out-of-range letters and a missing second letter become X
   always_comb begin
      pair_a = (req_data.letter_a < 5'(pfe_pkg::NLETTERS)) ?
               pfe_pkg::fold_letter(req_data.letter_a) : pfe_pkg::LTR_X;
      pair_b = (req_data.b_present && (req_data.letter_b < 5'(pfe_pkg::NLETTERS))) ?
               pfe_pkg::fold_letter(req_data.letter_b) : pfe_pkg::LTR_X;
   end

   always_ff @(posedge clock) begin
      if (cmd.pair_capture) begin
         place_a_ff  <= place_mem[pair_a];
         place_b_ff  <= place_mem[pair_b];
         notready_ff <= !ready_ff;
      end
   end

   always_comb begin
      r1 = pfe_pkg::row_of(place_a_ff);
      c1 = pfe_pkg::col_of(place_a_ff);
      r2 = pfe_pkg::row_of(place_b_ff);
      c2 = pfe_pkg::col_of(place_b_ff);
      if (r1 == r2) begin
         addr_a = pfe_pkg::cell_index(r1, pfe_pkg::wrap_inc(c1));
         addr_b = pfe_pkg::cell_index(r2, pfe_pkg::wrap_inc(c2));
      end else if (c1 == c2) begin
         addr_a = pfe_pkg::cell_index(pfe_pkg::wrap_inc(r1), c1);
         addr_b = pfe_pkg::cell_index(pfe_pkg::wrap_inc(r2), c2);
      end else begin
         addr_a = pfe_pkg::cell_index(r1, c2);
         addr_b = pfe_pkg::cell_index(r2, c1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cell_read) begin
         cell_a_ff <= square_mem[addr_a];
         cell_b_ff <= square_mem[addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         if (notready_ff) begin
            rsp_ff.cipher_a <= 5'd0;
            rsp_ff.cipher_b <= 5'd0;
            rsp_ff.status   <= pfe_pkg::STATUS_NOT_READY;
         end else begin
            rsp_ff.cipher_a <= cell_a_ff;
            rsp_ff.cipher_b <= cell_b_ff;
            rsp_ff.status   <= pfe_pkg::STATUS_OK;
         end
      end
   end

   always_comb begin
      sts.square_ready = ready_ff;
      sts.fill_last    = (fill_v_ff == 5'(pfe_pkg::NLETTERS - 1));
      sts.rsp_free     = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[src/playfair_cipher_encryptor_core.sv]
`timescale 1ns / 1ps
// key letter: next transaction accepted in the following cycle
// end of key on an incomplete square: one letter A to Z per cycle after acceptance
// pair: the place table read, the key square read and the result load are registered in turn,
//   and no new transaction is accepted until the result has been loaded
// one transaction in flight at a time; a result waits in the output register under stall
// synchronous active-high reset clears the square state and the result valid
// ----------------------------------------------------------------------------
// playfair_cipher_encryptor_core
// Builds a 5x5 Playfair key square and encrypts letter pairs with it.
// ----------------------------------------------------------------------------
module playfair_cipher_encryptor_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pfe_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pfe_pkg::rsp_type rsp_data
);

   pfe_pkg::cmd_type cmd;
   pfe_pkg::sts_type sts;

   pfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .sts       (sts),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   pfe_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

[src/pfe_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_checker
// Port-level checks on the Playfair encryptor, bound to the top level.
// ----------------------------------------------------------------------------
module pfe_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input pfe_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input pfe_pkg::rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // not-ready status carries zero letters
   a_notready_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == pfe_pkg::STATUS_NOT_READY |->
         rsp_data.cipher_a == 5'd0 && rsp_data.cipher_b == 5'd0)
      else $error("not-ready result with non-zero letters");

   // cipher letters come from the square, which never holds J
   a_cipher_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == pfe_pkg::STATUS_OK |->
         rsp_data.cipher_a < 5'(pfe_pkg::NLETTERS) && rsp_data.cipher_a != pfe_pkg::LTR_J &&
         rsp_data.cipher_b < 5'(pfe_pkg::NLETTERS) && rsp_data.cipher_b != pfe_pkg::LTR_J)
      else $error("cipher letter out of range");

   // an accepted pair keeps the input busy through the lookup
   a_pair_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.kind == pfe_pkg::KIND_PAIR |=> req_stall ##1 req_stall)
      else $error("input accepted during pair lookup");

   // no result straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind playfair_cipher_encryptor_core pfe_checker u_pfe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[bench/tb_playfair_cipher_encryptor_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_playfair_cipher_encryptor_core
// Builds key squares and encrypts pairs through the valid/stall channels.
// A directed table is walked first, then random key, fill and pair sessions.
// Results are checked against a cycle-free square model, or typed table rows.
// ----------------------------------------------------------------------------
module tb_playfair_cipher_encryptor_core;

   localparam logic [1:0] KIND_NONE = 2'd3;
   localparam int ITEM_TARGET  = 2000;
   localparam int IDLE_LIMIT   = 5000;
   localparam int DRAIN_CYCLES = 40;

   localparam pfe_pkg::rsp_type NO_CIPHER = '0;
   localparam pfe_pkg::rsp_type NOT_READY = '{5'd0, 5'd0, pfe_pkg::STATUS_NOT_READY};

   typedef struct {
      logic [1:0]       kind;
      logic [4:0]       la;
      logic [4:0]       lb;
      logic             bp;
      bit               typed;
      pfe_pkg::rsp_type want;
   } plan_row_type;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_kind_type;

   logic             clock;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   pfe_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   pfe_pkg::rsp_type rsp_data;

   // square built from the key MONARCHY, then J folded into I
   plan_row_type plan [27] = '{
      '{pfe_pkg::KIND_PAIR, 5'd0,  5'd25, 1'b1, 1'b1, NOT_READY},
      '{pfe_pkg::KIND_KEY,  5'd12, 5'd0,  1'b0, 1'b0, NO_CIPHER},
      '{pfe_pkg::KIND_KEY,  5'd14, 5'd31, 1'b1, 1'b0, NO_CIPHER},
      '{pfe_pkg::KIND_KEY,  5'd13, 5'd0,  1'b0, 1'b0, NO_CIPHER},
      '{pfe_pkg::KIND_KEY,  5'd0,  5'd0,  1'b0, 1'b0, NO_CIPHER},
      '{pfe_pkg::KIND_KEY,  5'd17, 5'd0,  1'b0, 1'b0, NO_CIPHER},
      '{pfe_pkg::KIND_KEY,  5'd2,  5'd0,  1'b0, 1'b0, NO_CIPHER},
      '{pfe_pkg::KIND_KEY,  5'd7,  5'd0,  1'b0, 1'b0, NO_CIPHER},
      '{pfe_pkg::KIND_KEY,  5'd24, 5'd0,  1'b0, 1'b0, NO_CIPHER},
      '{pfe_pkg::KIND_KEY,  5'd0,  5'd0,  1'b0, 1'b0, NO_CIPHER},
      '{pfe_pkg::KIND_KEY,  5'd31, 5'd31, 1'b1, 1'b0, NO_CIPHER},
      '{pfe_pkg::KIND_KEY,  5'd9,  5'd0,  1'b0, 1'b0, NO_CIPHER},
      '{pfe_pkg::KIND_PAIR, 5'd25, 5'd0,  1'b1, 1'b1, NOT_READY},
      '{pfe_pkg::KIND_FILL, 5'd0,  5'd0,  1'b0, 1'b0, NO_CIPHER},
      '{pfe_pkg::KIND_FILL, 5'd31, 5'd31, 1'b1, 1'b0, NO_CIPHER},
      '{pfe_pkg::KIND_PAIR, 5'd0,  5'd17, 1'b1, 1'b0, NO_CIPHER},
      '{pfe_pkg::KIND_PAIR, 5'd12, 5'd2,  1'b1, 1'b0, NO_CIPHER},
      '{pfe_pkg::KIND_PAIR, 5'd0,  5'd25, 1'b1, 1'b0, NO_CIPHER},
      '{pfe_pkg::KIND_PAIR, 5'd9,  5'd8,  1'b1, 1'b0, NO_CIPHER},
      '{pfe_pkg::KIND_PAIR, 5'd4,  5'd4,  1'b1, 1'b0, NO_CIPHER},
      '{pfe_pkg::KIND_PAIR, 5'd31, 5'd31, 1'b1, 1'b0, NO_CIPHER},
      '{pfe_pkg::KIND_PAIR, 5'd3,  5'd31, 1'b0, 1'b0, NO_CIPHER},
      '{KIND_NONE,          5'd31, 5'd31, 1'b1, 1'b0, NO_CIPHER},
      '{pfe_pkg::KIND_KEY,  5'd25, 5'd0,  1'b0, 1'b0, NO_CIPHER},
      '{pfe_pkg::KIND_PAIR, 5'd1,  5'd2,  1'b1, 1'b1, NOT_READY},
      '{pfe_pkg::KIND_FILL, 5'd0,  5'd0,  1'b0, 1'b0, NO_CIPHER},
      '{pfe_pkg::KIND_PAIR, 5'd25, 5'd23, 1'b1, 1'b0, NO_CIPHER}
   };

   // square model
   logic [4:0]                   sq_cell [pfe_pkg::CELLS];
   logic [4:0]                   sq_pos [pfe_pkg::NLETTERS];
   logic [pfe_pkg::NLETTERS-1:0] sq_used  = '0;
   int                           sq_count = 0;
   bit                           sq_ready = 1'b0;

   pfe_pkg::rsp_type cipher_q [$];
   int               err_count   = 0;
   int               items_sent  = 0;
   int               burst_left  = 0;
   int               idle_cycles = 0;
   int               stall_left  = 0;
   stall_kind_type   stall_mode  = STALL_NONE;

   playfair_cipher_encryptor_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task report_mismatch(input string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      err_count++;
   endtask

   function void seat_letter(input int v);
      if (v >= pfe_pkg::NLETTERS || v == int'(pfe_pkg::LTR_J) || sq_used[v] ||
          sq_count >= pfe_pkg::CELLS) begin
         return;
      end
      sq_cell[sq_count] = 5'(v);
      sq_pos[v]         = 5'(sq_count);
      sq_used[v]        = 1'b1;
      sq_count++;
   endfunction

   // returns 1 when the transaction yields a result, placed in r
   function bit encipher_step(input pfe_pkg::req_type t, output pfe_pkg::rsp_type r);
      int a, b, ra, ca, rb, cb;
      r = '0;
      case (t.kind)
         pfe_pkg::KIND_KEY: begin
            // a key letter on a finished square starts a fresh one
            if (sq_ready) begin
               sq_used  = '0;
               sq_count = 0;
               sq_ready = 1'b0;
            end
            if (t.letter_a < pfe_pkg::NLETTERS) begin
               seat_letter(int'(pfe_pkg::fold_letter(t.letter_a)));
            end
            return 1'b0;
         end
         pfe_pkg::KIND_FILL: begin
            if (!sq_ready) begin
               for (int v = 0; v < pfe_pkg::NLETTERS; v++) begin
                  seat_letter(v);
               end
               sq_ready = 1'b1;
            end
            return 1'b0;
         end
         pfe_pkg::KIND_PAIR: begin
            if (!sq_ready) begin
               r.status = pfe_pkg::STATUS_NOT_READY;
               return 1'b1;
            end
            a = (t.letter_a < pfe_pkg::NLETTERS) ? int'(t.letter_a) : int'(pfe_pkg::LTR_X);
            b = (t.b_present && t.letter_b < pfe_pkg::NLETTERS) ? int'(t.letter_b)
                                                                : int'(pfe_pkg::LTR_X);
            if (a == int'(pfe_pkg::LTR_J)) begin
               a = int'(pfe_pkg::LTR_I);
            end
            if (b == int'(pfe_pkg::LTR_J)) begin
               b = int'(pfe_pkg::LTR_I);
            end
            ra = int'(sq_pos[a]) / pfe_pkg::SIDE;
            ca = int'(sq_pos[a]) % pfe_pkg::SIDE;
            rb = int'(sq_pos[b]) / pfe_pkg::SIDE;
            cb = int'(sq_pos[b]) % pfe_pkg::SIDE;
            // doubled letters share a row, so they shift right too
            if (ra == rb) begin
               r.cipher_a = sq_cell[ra * pfe_pkg::SIDE + (ca + 1) % pfe_pkg::SIDE];
               r.cipher_b = sq_cell[rb * pfe_pkg::SIDE + (cb + 1) % pfe_pkg::SIDE];
            end else if (ca == cb) begin
               r.cipher_a = sq_cell[((ra + 1) % pfe_pkg::SIDE) * pfe_pkg::SIDE + ca];
               r.cipher_b = sq_cell[((rb + 1) % pfe_pkg::SIDE) * pfe_pkg::SIDE + cb];
            end else begin
               r.cipher_a = sq_cell[ra * pfe_pkg::SIDE + cb];
               r.cipher_b = sq_cell[rb * pfe_pkg::SIDE + ca];
            end
            r.status = pfe_pkg::STATUS_OK;
            return 1'b1;
         end
         default: begin
            return 1'b0;
         end
      endcase
   endfunction

   function pfe_pkg::req_type make_item(input logic [1:0] k, input logic [4:0] a,
                                        input logic [4:0] b, input logic bp);
      pfe_pkg::req_type t;
      t.kind      = k;
      t.letter_a  = a;
      t.letter_b  = b;
      t.b_present = bp;
      return t;
   endfunction

   function logic [4:0] rand_letter();
      if ($urandom_range(0, 11) == 0) begin
         return 5'($urandom_range(pfe_pkg::NLETTERS, 31));
      end
      return 5'($urandom_range(0, pfe_pkg::NLETTERS - 1));
   endfunction

   task push_item(input pfe_pkg::req_type t, input bit typed = 1'b0,
                  input pfe_pkg::rsp_type want = '0);
      pfe_pkg::rsp_type pred;
      bit               has;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      has = encipher_step(t, pred);
      if (has) begin
         cipher_q.push_back(typed ? want : pred);
      end
      if (t.kind != KIND_NONE) begin
         items_sent++;
      end
      if (burst_left > 0) begin
         burst_left--;
      end
      if (burst_left == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 10)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
   endtask

   // an optional key phase, an optional end of key (at times sent twice), then a run of pairs
   task run_session();
      int perm [pfe_pkg::NLETTERS];
      int n, j, tmp, style;
      style = $urandom_range(0, 19);
      if (style < 3) begin
         // whole alphabet: all 25 cells taken before the end of key
         for (int i = 0; i < pfe_pkg::NLETTERS; i++) begin
            perm[i] = i;
         end
         for (int i = pfe_pkg::NLETTERS - 1; i > 0; i--) begin
            j       = $urandom_range(0, i);
            tmp     = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
         end
         for (int i = 0; i < pfe_pkg::NLETTERS; i++) begin
            push_item(make_item(pfe_pkg::KIND_KEY, 5'(perm[i]), 5'($urandom),
                                1'($urandom)));
         end
      end else if (style >= 5) begin
         n = $urandom_range(1, 12);
         repeat (n) push_item(make_item(pfe_pkg::KIND_KEY, rand_letter(), 5'($urandom),
                                        1'($urandom)));
      end
      n = $urandom_range(0, 19);
      if (n != 0) begin
         push_item(make_item(pfe_pkg::KIND_FILL, 5'($urandom), 5'($urandom), 1'($urandom)));
      end
      if (n == 1) begin
         push_item(make_item(pfe_pkg::KIND_FILL, 5'($urandom), 5'($urandom), 1'($urandom)));
      end
      n = $urandom_range(1, 30);
      repeat (n) begin
         logic [4:0] a;
         if ($urandom_range(0, 29) == 0) begin
            push_item(make_item(KIND_NONE, 5'($urandom), 5'($urandom), 1'($urandom)));
         end
         a = rand_letter();
         push_item(make_item(pfe_pkg::KIND_PAIR, a,
                             ($urandom_range(0, 9) == 0) ? a : rand_letter(),
                             1'($urandom_range(0, 6) != 0)));
      end
   endtask

   initial begin : stimulus
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      burst_left = $urandom_range(1, 12);
      for (int k = 0; k < $size(plan); k++) begin
         push_item(make_item(plan[k].kind, plan[k].la, plan[k].lb, plan[k].bp),
                   plan[k].typed, plan[k].want);
      end
      while (items_sent < ITEM_TARGET) begin
         run_session();
      end
      @(negedge clock);
      req_valid <= 1'b0;
      while (cipher_q.size() != 0) begin
         @(posedge clock);
      end
      // a trailing fill can still be walking the alphabet
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   always @(posedge clock) begin : check_ciphers
      pfe_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (cipher_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", rsp_data));
         end else begin
            want = cipher_q.pop_front();
            if (rsp_data.cipher_a !== want.cipher_a) begin
               report_mismatch($sformatf("cipher_a %0d, want %0d",
                                         rsp_data.cipher_a, want.cipher_a));
            end
            if (rsp_data.cipher_b !== want.cipher_b) begin
               report_mismatch($sformatf("cipher_b %0d, want %0d",
                                         rsp_data.cipher_b, want.cipher_b));
            end
            if (rsp_data.status !== want.status) begin
               report_mismatch($sformatf("status %0b, want %0b",
                                         rsp_data.status, want.status));
            end
         end
      end
   end

   // receiver stalls in stretches, each with a character of its own
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_kind_type'($urandom_range(0, 3));
         stall_left = $urandom_range(10, 150);
      end
      stall_left--;
      case (stall_mode)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
         default:        rsp_stall <= ((stall_left % 8) < 5);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles = idle_cycles + 1;
      end
   end

endmodule

[files.f]
src/pfe_pkg.sv
src/pfe_ctrl.sv
src/pfe_datapath.sv
src/playfair_cipher_encryptor_core.sv
src/pfe_checker.sv
bench/tb_playfair_cipher_encryptor_core.sv
